@@ hdl/rrsp_pkg.sv @@
// Shared constants, request codes and the cell control bundle for the slot state pool.
// No dependencies; imported by rrsp_cell, round_robin_slot_state_pool_core and tb_top.
`default_nettype none

package rrsp_pkg;

    // Build defaults
    localparam int MAX_SLOTS_DEF  = 16;
    localparam int STATE_BITS_DEF = 4;

    // Fixed field widths
    localparam int REQ_W   = 3;
    localparam int ID_W    = 4;
    localparam int ST_IN_W = 4;
    localparam int SLOT_W  = 4;
    localparam int BUSY_W  = 5;
    localparam int CFG_W   = 5;

    localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_ACQUIRE    = 3'd0;
    localparam logic [REQ_W-1:0] REQ_TRANSITION = 3'd1;
    localparam logic [REQ_W-1:0] REQ_FORCE      = 3'd2;
    localparam logic [REQ_W-1:0] REQ_RELEASE    = 3'd3;
    localparam logic [REQ_W-1:0] REQ_POOL_RESET = 3'd4;

    // Control seen by every cell of the ring
    typedef struct packed {
        logic shift;   // rotate the ring by one cell
        logic wr_en;   // write the addressed cell
        logic clear;   // free every cell
    } t_cell_ctl;

endpackage

`default_nettype wire

@@ hdl/rrsp_cell.sv @@
// One slot cell of the pool ring: holds a state code, rotates to its neighbor, takes writes.
// Depends on rrsp_pkg.
`default_nettype none

module rrsp_cell #(
    parameter int STATE_BITS = rrsp_pkg::STATE_BITS_DEF,
    parameter int IDX_W      = 4,
    parameter int CELL_IDX   = 0
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  rrsp_pkg::t_cell_ctl        i_ctl,
    input  wire logic [IDX_W-1:0]      i_wr_idx,
    input  wire logic [STATE_BITS-1:0] i_wr_val,
    input  wire logic [STATE_BITS-1:0] i_nbr,
    output logic      [STATE_BITS-1:0] o_state
);
    import rrsp_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic [STATE_BITS-1:0] r_state;
    logic [STATE_BITS-1:0] n_state;

    always_comb begin
        priority if (i_ctl.clear) begin
            n_state = '0;
        end else if (i_ctl.wr_en && (i_wr_idx == MY_IDX)) begin
            n_state = i_wr_val;
        end else if (i_ctl.shift) begin
            n_state = i_nbr;
        end else begin
            n_state = r_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_state = r_state;

endmodule

`default_nettype wire

@@ hdl/round_robin_slot_state_pool_core.sv @@
// Top level of the round-robin slot state pool: request sequencer around a ring of slot cells.
// Depends on rrsp_pkg and rrsp_cell.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one request word: type, slot id,
//   expected state and new state. Output channel (o_out_valid / i_out_stall) returns one
//   result word per request: ok, slot and busy count over the slots in use.
//   Config channel (i_cfg_valid / o_cfg_ready) writes the capacity in use; ready is
//   always high and a write is meant to land only while no request is in flight.
//   After accept the sequencer reduces the search cursor below the capacity in use (it only
//   lies at or above it if the capacity shrank), then scans the ring and loads the result.
//   One request is in flight at a time, so a new word is taken only once the last one has
//   left the sequencer. The ring sets the pace: the slot cells rotate past the head
//   cell once per request, one cell per cycle, while the sequencer scans and counts.
//   The finished result sits in an output register, so the next request is accepted
//   while the receiver stalls; the sequencer then holds at its final step until the
//   output register frees up.
//   Synchronous reset frees every slot, clears the cursor and sets capacity to 16.
`default_nettype none

module round_robin_slot_state_pool_core #(
    parameter int MAX_SLOTS  = rrsp_pkg::MAX_SLOTS_DEF,
    parameter int STATE_BITS = rrsp_pkg::STATE_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [rrsp_pkg::REQ_W-1:0]   i_req_type,
    input  wire logic [rrsp_pkg::ID_W-1:0]    i_slot_id,
    input  wire logic [rrsp_pkg::ST_IN_W-1:0] i_expected_state,
    input  wire logic [rrsp_pkg::ST_IN_W-1:0] i_new_state,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic                              o_ok,
    output logic      [rrsp_pkg::SLOT_W-1:0]  o_slot_out,
    output logic      [rrsp_pkg::BUSY_W-1:0]  o_busy_total,
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [rrsp_pkg::CFG_W-1:0]   i_cfg_data
);
    import rrsp_pkg::*;

    localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CW = $clog2(MAX_SLOTS + 1);
    localparam int XW = (CW > CFG_W) ? CW : CFG_W;

    localparam logic [IW-1:0] K_LAST  = IW'(MAX_SLOTS - 1);
    localparam logic [XW-1:0] CAP_MAX = XW'(MAX_SLOTS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MOD  = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    // Sequencer registers
    logic [1:0]            r_state,    n_state;
    logic [REQ_W-1:0]      r_req,      n_req;
    logic [ID_W-1:0]       r_id,       n_id;
    logic [STATE_BITS-1:0] r_expect,   n_expect;
    logic [STATE_BITS-1:0] r_next,     n_next;
    logic [XW-1:0]         r_cap,      n_cap;
    logic [IW-1:0]         r_cursor,   n_cursor;
    logic [IW-1:0]         r_rem,      n_rem;
    logic [IW-1:0]         r_k,        n_k;
    logic [CW-1:0]         r_cnt,      n_cnt;
    logic                  r_fh,       n_fh;
    logic [IW-1:0]         r_hi,       n_hi;
    logic                  r_fl,       n_fl;
    logic [IW-1:0]         r_lo,       n_lo;
    logic [STATE_BITS-1:0] r_old,      n_old;
    logic                  r_out_valid, n_out_valid;
    logic                  r_ok,       n_ok;
    logic [SLOT_W-1:0]     r_slot,     n_slot;
    logic [BUSY_W-1:0]     r_busy,     n_busy;
    logic [CFG_W-1:0]      r_cfg_cap,  n_cfg_cap;

    // Ring
    logic [STATE_BITS-1:0] w_cell_q [MAX_SLOTS];
    t_cell_ctl             w_ctl;
    logic [IW-1:0]         w_wr_idx;
    logic [STATE_BITS-1:0] w_wr_val;
    logic [STATE_BITS-1:0] w_head;

    // Decision signals
    logic                  w_in_acc;
    logic                  w_out_free;
    logic                  w_done_ld;
    logic [XW-1:0]         w_cfg_x;
    logic [XW-1:0]         w_cap_eff;
    logic [XW-1:0]         w_k_x;
    logic                  w_inrange;
    logic                  w_found;
    logic [IW-1:0]         w_acq_slot;
    logic [XW-1:0]         w_acq_s1;
    logic                  w_old_busy;
    logic                  w_new_busy;
    logic                  d_ok;
    logic [SLOT_W-1:0]     d_slot;
    logic [CW-1:0]         d_busy;
    logic                  d_wr_en;
    logic [IW-1:0]         d_wr_idx;
    logic [STATE_BITS-1:0] d_wr_val;
    logic                  d_clear;
    logic                  d_cur_ld;
    logic [IW-1:0]         d_cur_val;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_SLOTS; gi++) begin : g_cell
            localparam int NBR = (gi + 1) % MAX_SLOTS;
            rrsp_cell #(
                .STATE_BITS (STATE_BITS),
                .IDX_W      (IW),
                .CELL_IDX   (gi)
            ) u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_ctl    (w_ctl),
                .i_wr_idx (w_wr_idx),
                .i_wr_val (w_wr_val),
                .i_nbr    (w_cell_q[NBR]),
                .o_state  (w_cell_q[gi])
            );
        end
    endgenerate

    assign w_head     = w_cell_q[0];
    assign w_in_acc   = i_in_valid && (r_state == ST_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_done_ld  = (r_state == ST_DONE) && w_out_free;

    // Clamp capacity into 1..MAX_SLOTS
    assign w_cfg_x   = XW'(r_cfg_cap);
    assign w_cap_eff = (w_cfg_x == '0) ? XW'(1) :
                       (w_cfg_x > CAP_MAX) ? CAP_MAX : w_cfg_x;

    assign w_k_x      = XW'(r_k);
    assign w_inrange  = XW'(r_id) < r_cap;
    assign w_found    = r_fh || r_fl;
    assign w_acq_slot = r_fh ? r_hi : r_lo;
    assign w_acq_s1   = XW'(w_acq_slot) + XW'(1);
    assign w_old_busy = (r_old != '0);
    assign w_new_busy = (r_next != '0);

    // Outcome of the request once the scan is complete
    always_comb begin
        d_ok      = 1'b0;
        d_slot    = '0;
        d_busy    = r_cnt;
        d_wr_en   = 1'b0;
        d_wr_idx  = IW'(r_id);
        d_wr_val  = r_next;
        d_clear   = 1'b0;
        d_cur_ld  = 1'b0;
        d_cur_val = '0;
        unique case (r_req)
            REQ_ACQUIRE: begin
                d_ok      = w_found;
                d_slot    = w_found ? SLOT_W'(w_acq_slot) : '0;
                d_wr_en   = w_found;
                d_wr_idx  = w_acq_slot;
                d_busy    = r_cnt + CW'(w_found && w_new_busy);
                d_cur_ld  = w_found;
                d_cur_val = (w_acq_s1 == r_cap) ? '0 : IW'(w_acq_s1);
            end
            REQ_TRANSITION: begin
                d_slot  = SLOT_W'(r_id);
                d_ok    = w_inrange && (r_old == r_expect);
                d_wr_en = d_ok;
                if (d_ok) begin
                    d_busy = r_cnt - CW'(w_old_busy) + CW'(w_new_busy);
                end
            end
            REQ_FORCE: begin
                d_slot  = SLOT_W'(r_id);
                d_ok    = w_inrange;
                d_wr_en = w_inrange;
                if (w_inrange) begin
                    d_busy = r_cnt - CW'(w_old_busy) + CW'(w_new_busy);
                end
            end
            REQ_RELEASE: begin
                d_slot   = SLOT_W'(r_id);
                d_ok     = w_inrange;
                d_wr_en  = w_inrange;
                d_wr_val = '0;
                if (w_inrange) begin
                    d_busy = r_cnt - CW'(w_old_busy);
                end
            end
            REQ_POOL_RESET: begin
                d_ok     = 1'b1;
                d_clear  = 1'b1;
                d_busy   = '0;
                d_cur_ld = 1'b1;
            end
            default: begin
                d_ok = 1'b0;
            end
        endcase
    end

    assign w_ctl.shift = (r_state == ST_SCAN);
    assign w_ctl.wr_en = w_done_ld && d_wr_en;
    assign w_ctl.clear = w_done_ld && d_clear;
    assign w_wr_idx    = d_wr_idx;
    assign w_wr_val    = d_wr_val;

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_id        = r_id;
        n_expect    = r_expect;
        n_next      = r_next;
        n_cap       = r_cap;
        n_cursor    = r_cursor;
        n_rem       = r_rem;
        n_k         = r_k;
        n_cnt       = r_cnt;
        n_fh        = r_fh;
        n_hi        = r_hi;
        n_fl        = r_fl;
        n_lo        = r_lo;
        n_old       = r_old;
        n_out_valid = r_out_valid;
        n_ok        = r_ok;
        n_slot      = r_slot;
        n_busy      = r_busy;
        n_cfg_cap   = r_cfg_cap;

        if (i_cfg_valid) begin
            n_cfg_cap = i_cfg_data;
        end

        // drop the result once taken
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_req    = i_req_type;
                    n_id     = i_slot_id;
                    n_expect = STATE_BITS'(i_expected_state);
                    n_next   = STATE_BITS'(i_new_state);
                    n_cap    = w_cap_eff;
                    n_rem    = r_cursor;
                    n_state  = ST_MOD;
                end
            end
            ST_MOD: begin
                // reduce cursor below capacity, one subtract a cycle
                if (XW'(r_rem) >= r_cap) begin
                    n_rem = IW'(XW'(r_rem) - r_cap);
                end else begin
                    n_k     = '0;
                    n_cnt   = '0;
                    n_fh    = 1'b0;
                    n_fl    = 1'b0;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // head cell holds slot r_k this cycle
                if ((w_k_x < r_cap) && (w_head != '0)) begin
                    n_cnt = r_cnt + CW'(1);
                end
                if (!r_fh && (r_k >= r_rem) && (w_k_x < r_cap) && (w_head == '0)) begin
                    n_fh = 1'b1;
                    n_hi = r_k;
                end
                if (!r_fl && (r_k < r_rem) && (w_head == '0)) begin
                    n_fl = 1'b1;
                    n_lo = r_k;
                end
                if (XW'(r_id) == w_k_x) begin
                    n_old = w_head;
                end
                if (r_k == K_LAST) begin
                    n_state = ST_DONE;
                end else begin
                    n_k = r_k + IW'(1);
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_ok        = d_ok;
                    n_slot      = d_slot;
                    n_busy      = BUSY_W'(d_busy);
                    if (d_cur_ld) begin
                        n_cursor = d_cur_val;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cursor    <= '0;
            r_out_valid <= 1'b0;
            r_cfg_cap   <= CAP_RESET;
        end else begin
            r_state     <= n_state;
            r_cursor    <= n_cursor;
            r_out_valid <= n_out_valid;
            r_cfg_cap   <= n_cfg_cap;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_id     <= n_id;
        r_expect <= n_expect;
        r_next   <= n_next;
        r_cap    <= n_cap;
        r_rem    <= n_rem;
        r_k      <= n_k;
        r_cnt    <= n_cnt;
        r_fh     <= n_fh;
        r_hi     <= n_hi;
        r_fl     <= n_fl;
        r_lo     <= n_lo;
        r_old    <= n_old;
        r_ok     <= n_ok;
        r_slot   <= n_slot;
        r_busy   <= n_busy;
    end

    assign o_in_stall   = (r_state != ST_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_ok         = r_ok;
    assign o_slot_out   = r_slot;
    assign o_busy_total = r_busy;
    assign o_cfg_ready  = 1'b1;

    // Busy count never exceeds the capacity the request ran with
    a_busy_le_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done_ld |=> (XW'(o_busy_total) <= r_cap))
        else $error("busy count above capacity");

    // Scan index walks the ring one cell per cycle
    a_scan_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && r_k != K_LAST) |=> (r_state == ST_SCAN && r_k == $past(r_k) + IW'(1)))
        else $error("scan index skipped");

    // A successful acquire leaves the cursor inside the slots in use
    a_cursor_in_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_done_ld && r_req == REQ_ACQUIRE && w_found) |=> (XW'(r_cursor) < r_cap))
        else $error("cursor outside capacity");

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
// Self-checking bench for round_robin_slot_state_pool_core: directed and random slot requests
// with a built-in pool predictor, random idling on both channels and capacity rewrites.
// Depends on rrsp_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_top;
    import rrsp_pkg::*;

    localparam int SLOTS = MAX_SLOTS_DEF;
    localparam int SETTLE_CYCLES = 3 * SLOTS + 8;
    localparam int HOLD_OFF_CYCLES = 300;

    // Codes the block must ignore
    localparam logic [REQ_W-1:0] REQ_UNKNOWN_FIRST = 3'd5;
    localparam logic [REQ_W-1:0] REQ_UNKNOWN_LAST  = 3'd7;

    typedef struct packed {
        logic [REQ_W-1:0]   kind;
        logic [ID_W-1:0]    id;
        logic [ST_IN_W-1:0] want;
        logic [ST_IN_W-1:0] next;
    } t_slot_req;

    typedef struct packed {
        logic              ok;
        logic [SLOT_W-1:0] slot;
        logic [BUSY_W-1:0] busy;
    } t_slot_outcome;

    logic               i_clk;
    logic               i_rst_n          = 1'b0;
    logic               i_in_valid       = 1'b0;
    logic [REQ_W-1:0]   i_req_type       = '0;
    logic [ID_W-1:0]    i_slot_id        = '0;
    logic [ST_IN_W-1:0] i_expected_state = '0;
    logic [ST_IN_W-1:0] i_new_state      = '0;
    logic               i_out_stall      = 1'b0;
    logic               i_cfg_valid      = 1'b0;
    logic [CFG_W-1:0]   i_cfg_data       = '0;
    logic               o_in_stall;
    logic               o_out_valid;
    logic               o_ok;
    logic [SLOT_W-1:0]  o_slot_out;
    logic [BUSY_W-1:0]  o_busy_total;
    logic               o_cfg_ready;

    round_robin_slot_state_pool_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_req_type      (i_req_type),
        .i_slot_id       (i_slot_id),
        .i_expected_state(i_expected_state),
        .i_new_state     (i_new_state),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_ok            (o_ok),
        .o_slot_out      (o_slot_out),
        .o_busy_total    (o_busy_total),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    // Pool mirror
    logic [ST_IN_W-1:0] pool_state [SLOTS];
    logic [SLOT_W-1:0]  cursor;
    logic [CFG_W-1:0]   capacity;

    t_slot_outcome pending_outcomes [$];
    t_slot_outcome head;

    int  failures     = 0;
    int  sent_count   = 0;
    int  checked      = 0;
    int  cfg_writes   = 0;
    int  grants       = 0;
    int  idle_pct     = 0;
    int  stall_pct    = 0;
    bit  offering     = 1'b0;
    bit  hold_request = 1'b0;
    int  hold_left    = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("round_robin_slot_state_pool_core: mismatch");
        $finish;
    end

    function automatic int used_slots();
        int c;
        c = int'(capacity);
        if (c < 1) c = 1;
        if (c > SLOTS) c = SLOTS;
        return c;
    endfunction

    function automatic t_slot_outcome apply_request(t_slot_req r);
        t_slot_outcome o;
        int cap;
        int s;
        bit found;
        cap   = used_slots();
        o     = '0;
        found = 1'b0;
        case (r.kind)
            REQ_ACQUIRE: begin
                for (int i = 0; i < cap; i++) begin
                    s = (int'(cursor) % cap + i) % cap;
                    if (!found && pool_state[s] == '0) begin
                        pool_state[s] = r.next;
                        cursor        = SLOT_W'((s + 1) % cap);
                        o.ok          = 1'b1;
                        o.slot        = SLOT_W'(s);
                        found         = 1'b1;
                    end
                end
                if (found) grants++;
            end
            REQ_TRANSITION: begin
                o.slot = r.id;
                if (r.id < cap && pool_state[r.id] == r.want) begin
                    pool_state[r.id] = r.next;
                    o.ok             = 1'b1;
                end
            end
            REQ_FORCE: begin
                o.slot = r.id;
                if (r.id < cap) begin
                    pool_state[r.id] = r.next;
                    o.ok             = 1'b1;
                end
            end
            REQ_RELEASE: begin
                o.slot = r.id;
                if (r.id < cap) begin
                    pool_state[r.id] = '0;
                    o.ok             = 1'b1;
                end
            end
            REQ_POOL_RESET: begin
                foreach (pool_state[k]) pool_state[k] = '0;
                cursor = '0;
                o.ok   = 1'b1;
            end
            default: ;
        endcase
        for (int i = 0; i < cap; i++)
            if (pool_state[i] != '0) o.busy++;
        return o;
    endfunction

    function automatic int draw_gap();
        int n;
        n = 0;
        while (n < 40 && $urandom_range(99) < idle_pct) n++;
        return n;
    endfunction

    function automatic t_slot_req make_req(logic [REQ_W-1:0] kind, int id, int want, int next);
        t_slot_req r;
        r.kind = kind;
        r.id   = ID_W'(id);
        r.want = ST_IN_W'(want);
        r.next = ST_IN_W'(next);
        return r;
    endfunction

    // Offer one request word and record its outcome once it is taken
    task automatic send_request(t_slot_req r);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            if (offering) i_in_valid <= 1'b0;
            offering = 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_req_type       <= r.kind;
        i_slot_id        <= r.id;
        i_expected_state <= r.want;
        i_new_state      <= r.next;
        offering = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        pending_outcomes.push_back(apply_request(r));
        sent_count++;
    endtask

    task automatic wait_drained();
        if (offering) i_in_valid <= 1'b0;
        offering = 1'b0;
        @(posedge i_clk);
        while (pending_outcomes.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_capacity(logic [CFG_W-1:0] value);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        capacity = value;
        cfg_writes++;
    endtask

    function automatic t_slot_req random_request();
        t_slot_req r;
        int cap;
        int pick;
        cap  = used_slots();
        pick = $urandom_range(99);
        r.id   = ($urandom_range(9) < 8) ? ID_W'($urandom_range(cap - 1))
                                         : ID_W'($urandom_range(15));
        r.want = ST_IN_W'($urandom_range(15));
        r.next = ST_IN_W'($urandom_range(15));
        if (pick < 35) r.kind = REQ_ACQUIRE;
        else if (pick < 60) begin
            r.kind = REQ_TRANSITION;
            // mostly a compare that should hit
            if ($urandom_range(9) < 7) r.want = pool_state[r.id];
        end
        else if (pick < 70) r.kind = REQ_FORCE;
        else if (pick < 92) r.kind = REQ_RELEASE;
        else if (pick < 95) r.kind = REQ_POOL_RESET;
        else r.kind = REQ_W'($urandom_range(REQ_UNKNOWN_LAST, REQ_UNKNOWN_FIRST));
        return r;
    endfunction

    function automatic logic [CFG_W-1:0] pick_capacity();
        case ($urandom_range(5))
            0: return 5'd1;
            1: return 5'd16;
            2: return 5'd0;
            3: return 5'd31;
            default: return CFG_W'($urandom_range(31, 1));
        endcase
    endfunction

    task automatic test_basic_requests();
        idle_pct  = 0;
        stall_pct = 0;
        send_request(make_req(REQ_ACQUIRE, 0, 0, 15));
        // acquire of state 0 leaves the slot free but moves the cursor
        send_request(make_req(REQ_ACQUIRE, 0, 0, 0));
        send_request(make_req(REQ_ACQUIRE, 15, 15, 9));
        send_request(make_req(REQ_TRANSITION, 0, 15, 7));
        send_request(make_req(REQ_TRANSITION, 0, 15, 1));
        send_request(make_req(REQ_TRANSITION, 15, 0, 15));
        send_request(make_req(REQ_FORCE, 14, 0, 15));
        send_request(make_req(REQ_RELEASE, 0, 15, 0));
        send_request(make_req(REQ_UNKNOWN_FIRST, 15, 15, 15));
        send_request(make_req(REQ_UNKNOWN_LAST, 0, 0, 0));
        send_request(make_req(REQ_POOL_RESET, 15, 15, 15));
    endtask

    task automatic test_capacity_limits();
        write_capacity(5'd1);
        send_request(make_req(REQ_ACQUIRE, 0, 0, 3));
        send_request(make_req(REQ_ACQUIRE, 0, 0, 3));     // pool full
        send_request(make_req(REQ_FORCE, 1, 0, 4));       // id beyond capacity
        send_request(make_req(REQ_TRANSITION, 15, 0, 4));
        send_request(make_req(REQ_RELEASE, 0, 0, 0));
        write_capacity(5'd0);                             // taken as one slot
        send_request(make_req(REQ_ACQUIRE, 0, 0, 5));
        send_request(make_req(REQ_RELEASE, 3, 0, 0));
        write_capacity(5'd31);                            // clipped to the full pool
        send_request(make_req(REQ_ACQUIRE, 0, 0, 2));
        send_request(make_req(REQ_ACQUIRE, 0, 0, 6));
        // shrink below the cursor so the scan starts at cursor mod capacity
        write_capacity(5'd2);
        send_request(make_req(REQ_RELEASE, 1, 0, 0));
        send_request(make_req(REQ_ACQUIRE, 0, 0, 15));
        send_request(make_req(REQ_POOL_RESET, 0, 0, 0));
        write_capacity(5'd16);
    endtask

    task automatic test_output_backpressure();
        idle_pct     = 0;
        stall_pct    = 0;
        hold_request = 1'b1;
        repeat (10) send_request(random_request());
        wait_drained();
    endtask

    task automatic test_random_traffic(int send_idle, int recv_stall, int items);
        idle_pct  = send_idle;
        stall_pct = recv_stall;
        for (int seg = 0; seg < 3; seg++) begin
            write_capacity(pick_capacity());
            repeat (items / 3) send_request(random_request());
        end
    endtask

    // Receiver side: random stall, or a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_request) begin
            hold_left    = HOLD_OFF_CYCLES;
            hold_request = 1'b0;
        end
        if (!i_rst_n) i_out_stall <= 1'b0;
        else if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_outcomes.size() == 0) begin
                $error("unexpected result word: ok %0d slot %0d busy %0d",
                       o_ok, o_slot_out, o_busy_total);
                failures++;
            end else begin
                head = pending_outcomes.pop_front();
                checked++;
                if (o_ok !== head.ok) begin
                    $error("ok: expected %0d, got %0d", head.ok, o_ok);
                    failures++;
                end
                if (o_slot_out !== head.slot) begin
                    $error("slot_out: expected %0d, got %0d", head.slot, o_slot_out);
                    failures++;
                end
                if (o_busy_total !== head.busy) begin
                    $error("busy_total: expected %0d, got %0d", head.busy, o_busy_total);
                    failures++;
                end
            end
        end
    end

    initial begin
        foreach (pool_state[k]) pool_state[k] = '0;
        cursor   = '0;
        capacity = CAP_RESET;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_requests();
        test_capacity_limits();
        test_output_backpressure();
        test_random_traffic(0, 0, 225);
        test_random_traffic(58, 0, 225);
        test_random_traffic(0, 58, 225);
        test_random_traffic(25, 25, 225);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Sent %0d requests over %0d capacity writes; %0d results checked, %0d grants.",
                 sent_count, cfg_writes, checked, grants);
        if (failures == 0) begin
            $display("round_robin_slot_state_pool_core: match");
        end else begin
            $display("round_robin_slot_state_pool_core: mismatch");
        end
        $finish;
    end

endmodule
